### hdl/mts_pkg.sv
`default_nettype none

package mts_pkg;

	localparam int DEPTH  = 256;
	localparam int DATA_W = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef logic [1:0] cmd_t;
	typedef logic [1:0] status_t;

	localparam cmd_t CMD_PUSH = 2'd0;
	localparam cmd_t CMD_POP  = 2'd1;
	localparam cmd_t CMD_LOOK = 2'd2;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_UNDER = 2'd1;
	localparam status_t ST_OVER  = 2'd2;

	typedef enum logic {
		S_IDLE,
		S_POP_RD
	} state_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic signed [DATA_W-1:0] push_value;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data_value;
		logic signed [DATA_W-1:0] min_value;
		logic [CNT_W-1:0]         entry_count;
		logic                     is_empty;
		status_t                  status;
	} result_t;

endpackage

`default_nettype wire

### hdl/mts_ram.sv
`default_nettype none

module mts_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hdl/min_tracking_stack.sv
// Push and look: result strobed the cycle after the accepting edge; a new item may be taken then.
// Pop: S_POP_RD waits on the registered read of the new tops from the value and minimum RAMs;
// busy stays high for the read cycle and the result is strobed with the new minimum.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Reset (arst_n low) empties both stacks at once; RAM contents are not cleared.
`default_nettype none

module min_tracking_stack (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire mts_pkg::item_t  item,
	output logic                 done,
	output mts_pkg::result_t     result
);
	import mts_pkg::*;

	state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] mcount_q, mcount_d;
	logic done_q, done_d;
	logic [DATA_W-1:0] top_q, mtop_q;
	logic [DATA_W-1:0] pop_data_q;
	logic pop_min_q;
	result_t res_q, res_d;

	logic acc;
	logic we_v, we_m, pop_go, pop_min;
	logic [CNT_W-1:0] vrd_idx, mrd_idx;
	logic [DATA_W-1:0] rd_v, rd_m;
	logic full;

	assign acc  = start && !busy;
	assign full = (count_q == CNT_W'(DEPTH));
	assign vrd_idx = count_q - CNT_W'(2);
	assign mrd_idx = mcount_q - CNT_W'(2);

	mts_ram #(.DEPTH(DEPTH), .WIDTH(DATA_W)) u_value_ram (
		.clk   (clk),
		.we    (we_v),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (item.push_value),
		.re    (pop_go),
		.raddr (vrd_idx[ADDR_W-1:0]),
		.rdata (rd_v)
	);

	mts_ram #(.DEPTH(DEPTH), .WIDTH(DATA_W)) u_min_ram (
		.clk   (clk),
		.we    (we_m),
		.waddr (mcount_q[ADDR_W-1:0]),
		.wdata (item.push_value),
		.re    (pop_go && pop_min),
		.raddr (mrd_idx[ADDR_W-1:0]),
		.rdata (rd_m)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (pop_go) begin
					state_d = S_POP_RD;
				end
			end
			S_POP_RD: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs and datapath
	always_comb begin
		busy     = (state_q == S_POP_RD);
		we_v     = 1'b0;
		we_m     = 1'b0;
		pop_go   = 1'b0;
		pop_min  = 1'b0;
		count_d  = count_q;
		mcount_d = mcount_q;
		done_d   = 1'b0;
		res_d    = res_q;

		if (state_q == S_POP_RD) begin
			// new tops arrive from the RAMs now
			done_d            = 1'b1;
			res_d.data_value  = pop_data_q;
			res_d.entry_count = count_q;
			res_d.is_empty    = (count_q == '0);
			res_d.status      = ST_OK;
			if (count_q == '0) begin
				res_d.min_value = '0;
			end else if (pop_min_q) begin
				res_d.min_value = rd_m;
			end else begin
				res_d.min_value = mtop_q;
			end
		end else if (acc) begin
			done_d = 1'b1;
			case (item.cmd)
				CMD_PUSH: begin
					if (full) begin
						res_d.data_value  = top_q;
						res_d.min_value   = mtop_q;
						res_d.entry_count = count_q;
						res_d.is_empty    = 1'b0;
						res_d.status      = ST_OVER;
					end else begin
						we_v    = 1'b1;
						count_d = count_q + CNT_W'(1);
						we_m    = (mcount_q == '0) ||
							($signed(item.push_value) <= $signed(mtop_q));
						if (we_m) begin
							mcount_d = mcount_q + CNT_W'(1);
						end
						res_d.data_value  = item.push_value;
						res_d.min_value   = we_m ? item.push_value : mtop_q;
						res_d.entry_count = count_d;
						res_d.is_empty    = 1'b0;
						res_d.status      = ST_OK;
					end
				end
				CMD_POP: begin
					if (count_q == '0) begin
						res_d.data_value  = '0;
						res_d.min_value   = '0;
						res_d.entry_count = count_q;
						res_d.is_empty    = 1'b1;
						res_d.status      = ST_UNDER;
					end else begin
						// hold the result until the new tops are read
						done_d  = 1'b0;
						pop_go  = 1'b1;
						pop_min = (mtop_q == top_q);
						count_d = count_q - CNT_W'(1);
						if (pop_min) begin
							mcount_d = mcount_q - CNT_W'(1);
						end
					end
				end
				default: begin
					// look, and the unused code acts as look
					if (count_q == '0) begin
						res_d.data_value  = '0;
						res_d.min_value   = '0;
						res_d.is_empty    = 1'b1;
						res_d.status      = ST_UNDER;
					end else begin
						res_d.data_value  = top_q;
						res_d.min_value   = mtop_q;
						res_d.is_empty    = 1'b0;
						res_d.status      = ST_OK;
					end
					res_d.entry_count = count_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			mcount_q <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			mcount_q <= mcount_d;
			done_q   <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (we_v) begin
			top_q <= item.push_value;
		end
		if (we_m) begin
			mtop_q <= item.push_value;
		end
		if (pop_go) begin
			pop_data_q <= top_q;
			pop_min_q  <= pop_min;
		end
		if (state_q == S_POP_RD) begin
			top_q <= rd_v;
			if (pop_min_q) begin
				mtop_q <= rd_m;
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

	a_empty_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) == (mcount_q == '0))
		else $error("value and minimum stacks disagree on emptiness");

	a_min_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		mcount_q <= count_q)
		else $error("minimum stack deeper than value stack");

	a_pop_wait: assert property (@(posedge clk) disable iff (!arst_n)
		pop_go |=> busy && !done ##1 done && !busy)
		else $error("pop beat not completed after the RAM read");

	a_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_OVER |-> result.entry_count == CNT_W'(DEPTH))
		else $error("overflow reported on a stack that is not full");

endmodule

`default_nettype wire

### dv/min_tracking_stack_test.sv
module min_tracking_stack_test;
	import mts_pkg::*;

	// cmd code that the block decodes like a look
	localparam cmd_t CMD_SPARE = 2'd3;
	localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item   = '0;
	logic    busy;
	logic    done;
	result_t result;

	// shadow of the two stacks
	logic signed [DATA_W-1:0] val_mem [DEPTH];
	logic signed [DATA_W-1:0] min_mem [DEPTH];
	int val_depth = 0;
	int min_depth = 0;

	result_t pending_results[$];
	int      error_count = 0;
	int      burst_left  = 0;

	min_tracking_stack i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	always #10 clk = ~clk;

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic result_t predict_stack_op(item_t it);
		result_t r;
		logic signed [DATA_W-1:0] v;
		r = '0;
		r.status = ST_OK;
		case (it.cmd)
			CMD_PUSH: begin
				v = it.push_value;
				if (val_depth == DEPTH) begin
					// full: drop the value, report the unchanged top
					r.status     = ST_OVER;
					r.data_value = val_mem[val_depth-1];
				end else begin
					val_mem[val_depth] = v;
					val_depth++;
					if (min_depth < DEPTH &&
					    (min_depth == 0 || v <= min_mem[min_depth-1])) begin
						min_mem[min_depth] = v;
						min_depth++;
					end
					r.data_value = v;
				end
			end
			CMD_POP: begin
				if (val_depth == 0) begin
					r.status = ST_UNDER;
				end else begin
					val_depth--;
					r.data_value = val_mem[val_depth];
					if (min_depth > 0 && min_mem[min_depth-1] == r.data_value)
						min_depth--;
				end
			end
			default: begin
				if (val_depth == 0)
					r.status = ST_UNDER;
				else
					r.data_value = val_mem[val_depth-1];
			end
		endcase
		if (val_depth > 0 && min_depth > 0)
			r.min_value = min_mem[min_depth-1];
		r.entry_count = CNT_W'(val_depth);
		r.is_empty    = (val_depth == 0);
		return r;
	endfunction

	task automatic note_error(string msg);
		error_count++;
		if (error_count <= 10)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				note_error($sformatf("unexpected result data %0d min %0d count %0d",
					result.data_value, result.min_value, result.entry_count));
			end else begin
				want = pending_results.pop_front();
				if (result.data_value !== want.data_value ||
				    result.min_value !== want.min_value ||
				    result.entry_count !== want.entry_count ||
				    result.is_empty !== want.is_empty ||
				    result.status !== want.status)
					note_error($sformatf({"exp data %0d min %0d count %0d empty %0b st %0d, ",
						"got data %0d min %0d count %0d empty %0b st %0d"},
						want.data_value, want.min_value, want.entry_count,
						want.is_empty, want.status,
						result.data_value, result.min_value, result.entry_count,
						result.is_empty, result.status));
			end
		end
	end

	// Send one beat, then either keep start high or open a gap.
	task automatic send_op(cmd_t c, logic signed [DATA_W-1:0] v);
		item_t it;
		it.cmd        = c;
		it.push_value = v;
		item  <= it;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(predict_stack_op(it));
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 12);
			start <= 1'b0;
			repeat ($urandom_range(1, 7))
				@(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6:    return int'($urandom_range(0, 16)) - 8;
			7:          return VAL_MAX;
			8:          return VAL_MIN;
			default:    return $urandom_range(0, 1) ? '1 : '0;
		endcase
	endfunction

	function automatic cmd_t pick_cmd(int push_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < push_pct)
			return CMD_PUSH;
		if (r < push_pct + (100 - push_pct) * 3 / 4)
			return CMD_POP;
		return $urandom_range(0, 1) ? CMD_LOOK : CMD_SPARE;
	endfunction

	task automatic test_empty_and_extremes();
		send_op(CMD_POP, 0);
		send_op(CMD_LOOK, '1);
		send_op(CMD_SPARE, $urandom);
		send_op(CMD_PUSH, VAL_MAX);
		send_op(CMD_PUSH, 5);
		send_op(CMD_PUSH, 5);
		send_op(CMD_PUSH, 7);
		send_op(CMD_PUSH, -1);
		send_op(CMD_PUSH, VAL_MIN);
		send_op(CMD_PUSH, VAL_MIN);
		send_op(CMD_LOOK, 0);
		send_op(CMD_SPARE, VAL_MAX);
		// unwind: equal minimums must leave one at a time
		repeat (8)
			send_op(CMD_POP, $urandom);
		send_op(CMD_POP, VAL_MIN);
		send_op(CMD_SPARE, 0);
		send_op(CMD_PUSH, 0);
		send_op(CMD_POP, '1);
	endtask

	// Fill with a non-increasing run so both stacks reach full, then overflow.
	task automatic test_fill_and_overflow();
		logic signed [DATA_W-1:0] v;
		while (val_depth != 0)
			send_op(CMD_POP, $urandom);
		v = $urandom;
		if (v < VAL_MIN + 1000)
			v = 0;
		repeat (DEPTH) begin
			send_op(CMD_PUSH, v);
			v = v - int'($urandom_range(0, 3));
		end
		send_op(CMD_PUSH, VAL_MIN);
		send_op(CMD_PUSH, VAL_MAX);
		send_op(CMD_PUSH, pick_value());
		send_op(CMD_LOOK, $urandom);
		repeat (DEPTH + 1)
			send_op(CMD_POP, $urandom);
		send_op(CMD_LOOK, 0);
	endtask

	task automatic test_random_walk(int n_items);
		int left;
		int push_pct;
		int phase_len;
		left = n_items;
		while (left > 0) begin
			case ($urandom_range(0, 3))
				0: push_pct = 20;
				1: push_pct = 50;
				2: push_pct = 80;
				default: push_pct = 95;
			endcase
			phase_len = $urandom_range(20, 200);
			for (int k = 0; k < phase_len && left > 0; k++) begin
				send_op(pick_cmd(push_pct), pick_value());
				left--;
			end
		end
	endtask

	initial begin
		int wait_cycles;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_extremes();
		test_fill_and_overflow();
		test_random_walk(1300);

		start <= 1'b0;
		wait_cycles = 0;
		while (pending_results.size() != 0 && wait_cycles < 1000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (5)
			@(posedge clk);

		if (error_count == 0 && pending_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
